@@ sv/knnl_pkg.sv @@
// Package for the k-nearest-neighbour list block: field widths and defaults.
// No dependencies.
`default_nettype none
package knnl_pkg;
   localparam int MaxPoints     = 256;
   localparam int MaxNeighbours = 8;
   localparam int CoordBits     = 16;
   localparam int IndexBits     = 8;
   localparam int CsrIndexBits  = 2;
   localparam int CsrDataBits   = 16;
   localparam logic [CsrIndexBits-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_COUNT  = 2'd2;
   localparam logic [CsrIndexBits-1:0] CSR_WRAP   = 2'd3;
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] point_index;
      logic [15:0] x_coord;
      logic [15:0] y_coord;
      logic       last_point;
   } req_type;

   typedef struct packed {
      logic [2:0]  rank;
      logic [7:0]  neighbour_index;
      logic [16:0] distance;
      logic        found;
      logic        last_of_list;
   } rsp_type;

   typedef struct packed {
      logic [CsrIndexBits-1:0] index;
      logic [CsrDataBits-1:0]  data;
   } csr_type;
endpackage
`default_nettype wire

@@ sv/knnl_req_if.sv @@
// Request handshake channel interface for the block.
// Depends on knnl_pkg.
`default_nettype none
interface knnl_req_if import knnl_pkg::*; ;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/knnl_rsp_if.sv @@
// Result channel interface.
// Depends on knnl_pkg.
`default_nettype none
interface knnl_rsp_if import knnl_pkg::*; ;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/knnl_csr_if.sv @@
// Configuration write channel interface.
// Depends on knnl_pkg.
`default_nettype none
interface knnl_csr_if import knnl_pkg::*; ;
   logic valid;
   logic ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/k_nearest_neighbour_lists.sv @@
// A load writes the point's coordinates. A last load clears all 2048 list slots, one per cycle,
// then computes each pair's distance and inserts it into both points' lists, in one sequencer.
// A read forms each result with a bit-serial square root and waits while a result is held.
// One transaction is in flight at a time; ready is low until the sequencer is idle again.
// Reset (synchronous) restores register defaults and an empty point count.
// Depends on knnl_pkg and the channel interfaces.
`default_nettype none
module k_nearest_neighbour_lists import knnl_pkg::*; #(
   parameter int MAX_POINTS     = MaxPoints,
   parameter int MAX_NEIGHBOURS = MaxNeighbours
) (
   input  wire logic  clock,
   input  wire logic  reset,
   knnl_req_if.sink   req,
   knnl_rsp_if.source rsp,
   knnl_csr_if.sink   csr
);
   localparam int PB = $clog2(MAX_POINTS);
   localparam int NB = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
   localparam int CB = $clog2(MAX_NEIGHBOURS + 1);
   localparam int SB = PB + NB;
   localparam int DEPTH = MAX_POINTS * MAX_NEIGHBOURS;

   localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_PRD = 4'd2, S_DIST = 4'd3,
      S_SQ = 4'd4, S_INSR = 4'd5, S_INSC = 4'd6, S_RRD = 4'd7, S_RWAIT = 4'd8,
      S_SQRT = 4'd9, S_OUT = 4'd10, S_PRD2 = 4'd11, S_INSW = 4'd12;

   logic [3:0] st_ff, st_in;
   logic [15:0] w_ff, h_ff;
   logic [3:0] nc_ff;
   logic wrap_ff;
   logic [PB:0] total_ff;

   logic [CoordBits-1:0] xm [MAX_POINTS];
   logic [CoordBits-1:0] ym [MAX_POINTS];
   logic [33:0] dm [DEPTH];
   logic [7:0]  nm [DEPTH];
   logic        vm [DEPTH];

   logic [CB-1:0] cnt_eff;
   always_comb begin
      cnt_eff = (nc_ff == 4'd0) ? CB'(1) : CB'(nc_ff);
      if (32'(nc_ff) > MAX_NEIGHBOURS) cnt_eff = CB'(MAX_NEIGHBOURS);
   end

   logic [PB-1:0] pi_ff, pj_ff, pt_ff;
   logic [SB-1:0] clr_ff;
   logic [CoordBits-1:0] xa_ff, ya_ff, xr, yr;
   logic signed [CoordBits+1:0] dx_ff, dy_ff;
   logic [33:0] d_ff, sqa_ff;
   logic side_ff;
   logic [CB-1:0] pos_ff, cnt_ff;
   logic [33:0] rdd;
   logic [7:0] rdn;
   logic rdv;
   logic [CB-1:0] r_ff;
   logic [33:0] sv_ff, sres_ff, sbit_ff;
   logic sfound_ff;
   logic [7:0] snb_ff;
   logic [PB-1:0] rp_ff;
   rsp_type rsp_ff;
   logic rsp_v_ff;

   logic [SB-1:0] raddr, waddr;
   logic wen;
   logic [33:0] wd;
   logic [7:0] wn;
   logic wv;

   assign req.ready = (st_ff == S_IDLE);
   assign csr.ready = 1'b1;
   wire req_go = req.valid && req.ready;
   wire idx_ok = 32'(req.data.point_index) < MAX_POINTS;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= 16'd6400; h_ff <= 16'd6400; nc_ff <= 4'd4; wrap_ff <= 1'b0;
      end else if (csr.valid) begin
         case (csr.data.index)
            CSR_WIDTH:  w_ff <= csr.data.data;
            CSR_HEIGHT: h_ff <= csr.data.data;
            CSR_COUNT:  nc_ff <= csr.data.data[3:0];
            CSR_WRAP:   wrap_ff <= csr.data.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_go && idx_ok && req.data.func == FUNC_LOAD) begin
         xm[PB'(req.data.point_index)] <= CoordBits'(req.data.x_coord);
         ym[PB'(req.data.point_index)] <= CoordBits'(req.data.y_coord);
      end
      xr <= xm[pt_ff];
      yr <= ym[pt_ff];
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         dm[waddr] <= wd; nm[waddr] <= wn; vm[waddr] <= wv;
      end
      rdd <= dm[raddr]; rdn <= nm[raddr]; rdv <= vm[raddr];
   end

   // Minimum-image correction reduces to comparing twice the offset with the period.
   function automatic logic signed [17:0] wrapa(input logic signed [17:0] d,
         input logic [15:0] p);
      logic signed [17:0] ps;
      logic signed [17:0] r;
      ps = $signed({2'b0, p});
      r = d;
      if (ps != 0 && (d <<< 1) > ps) r = d - ps;
      else if (ps != 0 && (d <<< 1) < -ps) r = d + ps;
      return r;
   endfunction

   wire [PB-1:0] cur_p = side_ff ? pj_ff : pi_ff;
   wire [PB-1:0] cur_o = side_ff ? pi_ff : pj_ff;
   wire [CB-1:0] posm1 = pos_ff - CB'(1);
   wire [33:0] str = sres_ff + sbit_ff;

   always_comb begin
      raddr = {cur_p, NB'(posm1)};
      if (st_ff == S_RRD) raddr = {rp_ff, NB'(r_ff)};
      wen = 1'b0; waddr = {cur_p, NB'(pos_ff)}; wd = rdd; wn = rdn; wv = rdv;
      if (st_ff == S_CLR) begin
         wen = 1'b1; waddr = clr_ff; wv = 1'b0;
      end
      if (st_ff == S_INSC) begin
         if (pos_ff != 0 && rdv && !(d_ff < rdd)) begin
            wen = (pos_ff < cnt_ff); wd = d_ff; wn = 8'(cur_o); wv = 1'b1;
         end else if (pos_ff < cnt_ff) wen = 1'b1;
      end
      if (st_ff == S_INSW) begin
         wen = 1'b1; waddr = {cur_p, NB'(0)}; wd = d_ff; wn = 8'(cur_o); wv = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; total_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_v_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (req_go && idx_ok) begin
               if (req.data.func == FUNC_LOAD) begin
                  if (req.data.last_point) begin
                     total_ff <= (PB+1)'(req.data.point_index) + 1'b1;
                     clr_ff <= '0; cnt_ff <= cnt_eff; st_ff <= S_CLR;
                  end
               end else begin
                  rp_ff <= PB'(req.data.point_index); r_ff <= '0; st_ff <= S_RRD;
               end
            end
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == DEPTH - 1) begin
                  pi_ff <= '0; pj_ff <= PB'(1); pt_ff <= '0;
                  st_ff <= (total_ff > 1) ? S_PRD : S_IDLE;
               end
            end
            S_PRD: begin pt_ff <= pj_ff; st_ff <= S_PRD2; end
            S_PRD2: begin
               if (pj_ff == pi_ff + 1'b1) begin
                  xa_ff <= xr; ya_ff <= yr;
               end
               st_ff <= S_DIST;
            end
            S_DIST: begin
               dx_ff <= $signed({2'b0, xr}) - $signed({2'b0, xa_ff});
               dy_ff <= $signed({2'b0, yr}) - $signed({2'b0, ya_ff});
               st_ff <= S_SQ; side_ff <= 1'b0;
            end
            S_SQ: begin
               automatic logic signed [17:0] a = wrap_ff ? wrapa(dx_ff, w_ff) : dx_ff;
               automatic logic signed [17:0] b = wrap_ff ? wrapa(dy_ff, h_ff) : dy_ff;
               automatic logic signed [35:0] m = side_ff ? 36'(b) : 36'(a);
               if (side_ff == 1'b0) begin
                  sqa_ff <= 34'(m * m); side_ff <= 1'b1;
               end else begin
                  d_ff <= sqa_ff + 34'(m * m); side_ff <= 1'b0;
                  pos_ff <= cnt_ff; st_ff <= S_INSR;
               end
            end
            S_INSR: st_ff <= (pos_ff == 0) ? S_INSW : S_INSC;
            S_INSC: begin
               if (pos_ff != 0 && rdv && !(d_ff < rdd)) begin
                  st_ff <= S_OUT;
               end else begin
                  pos_ff <= posm1;
                  st_ff <= (posm1 == 0) ? S_INSW : S_INSR;
               end
            end
            S_INSW: st_ff <= S_OUT;
            S_OUT: begin
               if (side_ff == 1'b0) begin
                  side_ff <= 1'b1; pos_ff <= cnt_ff; st_ff <= S_INSR;
               end else if (32'(pj_ff) + 1 < 32'(total_ff)) begin
                  pj_ff <= pj_ff + 1'b1; pt_ff <= pj_ff + 1'b1; st_ff <= S_PRD2;
               end else if (32'(pi_ff) + 2 < 32'(total_ff)) begin
                  pi_ff <= pi_ff + 1'b1; pj_ff <= pi_ff + 2'd2; pt_ff <= pi_ff + 1'b1;
                  st_ff <= S_PRD;
               end else st_ff <= S_IDLE;
            end
            S_RRD: if (!rsp_v_ff) st_ff <= S_RWAIT;
            S_RWAIT: begin
               sfound_ff <= rdv; snb_ff <= rdn; sv_ff <= rdd;
               sres_ff <= '0; sbit_ff <= 34'(1) << 32; st_ff <= S_SQRT;
            end
            S_SQRT: begin
               if (sbit_ff == 0) begin
                  automatic logic hit = sfound_ff && (total_ff != '0) && (r_ff < cnt_ff);
                  rsp_ff.rank <= 3'(r_ff);
                  rsp_ff.found <= hit;
                  rsp_ff.neighbour_index <= hit ? snb_ff : 8'd0;
                  rsp_ff.distance <= hit ? 17'(sres_ff) : 17'd0;
                  rsp_ff.last_of_list <= (r_ff + 1'b1 == cnt_eff);
                  rsp_v_ff <= 1'b1;
                  r_ff <= r_ff + 1'b1;
                  st_ff <= (r_ff + 1'b1 == cnt_eff) ? S_IDLE : S_RRD;
               end else begin
                  if (sv_ff >= str) begin
                     sv_ff <= sv_ff - str; sres_ff <= (sres_ff >> 1) + sbit_ff;
                  end else sres_ff <= sres_ff >> 1;
                  sbit_ff <= sbit_ff >> 2;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.data = rsp_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
   a_pos: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_INSC) |-> (pos_ff <= cnt_ff)) else $error("insert position");
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the k-nearest-neighbour list block.
// Loads point sets, runs sweeps under several register settings and checks every
// list read against a predictor. Depends on knnl_pkg and the channel interfaces.
`default_nettype none
module testbench;
   import knnl_pkg::*;

   localparam int CycleLimit = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   knnl_req_if req_ch ();
   knnl_rsp_if rsp_ch ();
   knnl_csr_if csr_ch ();

   k_nearest_neighbour_lists i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   always #10 clock = ~clock;

   logic [15:0] model_width = 16'd6400;
   logic [15:0] model_height = 16'd6400;
   logic [3:0]  model_count = 4'd4;
   logic        model_wrap = 1'b0;
   logic [15:0] point_x [MaxPoints];
   logic [15:0] point_y [MaxPoints];
   longint unsigned nbr_sq [MaxPoints][MaxNeighbours];
   logic [7:0]  nbr_index [MaxPoints][MaxNeighbours];
   bit          nbr_valid [MaxPoints][MaxNeighbours];

   rsp_type expected_lists [$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  items_sent = 0;
   bit  quiet = 1'b0;

   function automatic int kept_count();
      if (model_count == 0) return 1;
      if (model_count > MaxNeighbours) return MaxNeighbours;
      return model_count;
   endfunction

   function automatic longint wrapped_delta(longint d, longint period);
      if (2 * d > period && (d - period) * (d - period) < d * d) return d - period;
      if (2 * d < -period && (d + period) * (d + period) < d * d) return d + period;
      return d;
   endfunction

   function automatic longint unsigned pair_sq_distance(int a, int b);
      longint dx;
      longint dy;
      dx = longint'(point_x[b]) - longint'(point_x[a]);
      dy = longint'(point_y[b]) - longint'(point_y[a]);
      if (model_wrap) begin
         dx = wrapped_delta(dx, longint'(model_width));
         dy = wrapped_delta(dy, longint'(model_height));
      end
      return longint'(dx * dx + dy * dy);
   endfunction

   function automatic int floor_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return int'(res);
   endfunction

   function automatic void insert_neighbour(int p, int nb, longint unsigned d, int cnt);
      int pos;
      pos = cnt;
      while (pos > 0) begin
         if (nbr_valid[p][pos-1] && !(d < nbr_sq[p][pos-1])) break;
         pos--;
      end
      if (pos >= cnt) return;
      for (int l = cnt - 1; l > pos; l--) begin
         nbr_sq[p][l] = nbr_sq[p][l-1];
         nbr_index[p][l] = nbr_index[p][l-1];
         nbr_valid[p][l] = nbr_valid[p][l-1];
      end
      nbr_sq[p][pos] = d;
      nbr_index[p][pos] = nb[7:0];
      nbr_valid[p][pos] = 1'b1;
   endfunction

   function automatic void sweep_lists(int total);
      int cnt;
      longint unsigned d;
      cnt = kept_count();
      foreach (nbr_valid[p, s]) nbr_valid[p][s] = 1'b0;
      for (int i = 0; i + 1 < total; i++) begin
         for (int j = i + 1; j < total; j++) begin
            d = pair_sq_distance(i, j);
            insert_neighbour(i, j, d, cnt);
            insert_neighbour(j, i, d, cnt);
         end
      end
   endfunction

   function automatic void predict_request(req_type item);
      rsp_type r;
      int cnt;
      int idx;
      idx = item.point_index;
      if (item.func == FUNC_LOAD) begin
         point_x[idx] = item.x_coord;
         point_y[idx] = item.y_coord;
         if (item.last_point) sweep_lists(idx + 1);
      end else begin
         cnt = kept_count();
         for (int k = 0; k < cnt; k++) begin
            r.rank = k[2:0];
            r.found = nbr_valid[idx][k];
            r.neighbour_index = r.found ? nbr_index[idx][k] : 8'd0;
            r.distance = r.found ? 17'(floor_sqrt(nbr_sq[idx][k])) : 17'd0;
            r.last_of_list = (k + 1 == cnt);
            expected_lists.push_back(r);
         end
      end
   endfunction

   task automatic send_request(logic func, int idx, int x, int y, bit last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.data.func = func;
      req_ch.data.point_index = idx[7:0];
      req_ch.data.x_coord = x[15:0];
      req_ch.data.y_coord = y[15:0];
      req_ch.data.last_point = last;
      do @(posedge clock); while (!req_ch.ready);
      predict_request(req_ch.data);
      items_sent++;
   endtask

   task automatic load_point(int idx, int x, int y, bit last);
      send_request(FUNC_LOAD, idx, x, y, last);
   endtask

   task automatic read_list(int idx);
      send_request(FUNC_READ, idx, $urandom(), $urandom(), $urandom_range(0, 1));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      do @(posedge clock); while (!req_ch.ready || expected_lists.size() != 0);
   endtask

   task automatic write_register(logic [CsrIndexBits-1:0] index, int value);
      wait_idle();
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.data.index = index;
      csr_ch.data.data = value[15:0];
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         CSR_WIDTH: model_width = value[15:0];
         CSR_HEIGHT: model_height = value[15:0];
         CSR_COUNT: model_count = value[3:0];
         default: model_wrap = value[0];
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic configure(int width, int height, int count, int wrap);
      write_register(CSR_WIDTH, width);
      write_register(CSR_HEIGHT, height);
      write_register(CSR_COUNT, count);
      write_register(CSR_WRAP, wrap);
   endtask

   task automatic read_all(int total);
      for (int i = 0; i < total; i++) read_list(i);
   endtask

   task automatic test_defaults();
      load_point(0, 0, 0, 0);
      load_point(1, 65535, 65535, 0);
      load_point(2, 6400, 0, 0);
      load_point(3, 0, 6400, 1);
      read_all(4);
      read_list(200);
   endtask

   task automatic test_wrap_extremes();
      configure(65535, 1, 8, 1);
      load_point(0, 0, 0, 0);
      load_point(1, 65535, 65535, 0);
      load_point(2, 32767, 1, 0);
      load_point(3, 32768, 65534, 0);
      load_point(4, 100, 30000, 1);
      read_all(5);
   endtask

   task automatic test_zero_period();
      configure(0, 6400, 3, 1);
      load_point(0, 10, 6390, 0);
      load_point(1, 6390, 10, 0);
      load_point(2, 3200, 3200, 1);
      read_all(3);
   endtask

   task automatic test_count_limits();
      write_register(CSR_COUNT, 0);
      load_point(0, 5, 5, 0);
      load_point(1, 9, 5, 0);
      load_point(2, 5, 9, 1);
      read_list(0);
      write_register(CSR_COUNT, 15);
      read_all(3);
      write_register(CSR_COUNT, 9);
      load_point(2, 5, 9, 1);
      read_list(1);
   endtask

   task automatic test_equal_distances();
      configure(6400, 6400, 8, 0);
      for (int i = 0; i < 9; i++) load_point(i, (i % 3) * 64, (i / 3) * 64, i == 8);
      read_all(9);
   endtask

   task automatic test_large_set();
      write_register(CSR_COUNT, 1);
      load_point(255, 65535, 0, 0);
      for (int i = 0; i < 160; i++) load_point(i, $urandom(), $urandom(), i == 159);
      read_list(0);
      read_list(159);
      read_list(255);
   endtask

   task automatic test_random();
      int total;
      int base;
      int spread;
      while (items_sent < 280) begin
         quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: configure($urandom(), $urandom(), $urandom_range(0, 15), $urandom_range(0, 1));
            1: configure($urandom_range(1, 300), $urandom_range(1, 300),
                  $urandom_range(1, 8), 1);
            2: configure(65535, 65535, $urandom_range(1, 8), $urandom_range(0, 1));
            default: configure(6400, 6400, 4, $urandom_range(0, 1));
         endcase
         total = $urandom_range(2, 24);
         spread = ($urandom_range(0, 1) == 0) ? 16 : 65535;
         base = $urandom();
         for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 9) == 0) load_point($urandom_range(0, 255), $urandom(),
                  $urandom(), 0);
            load_point(i, (base + $urandom_range(0, spread)) & 16'hFFFF,
               (base + $urandom_range(0, spread)) & 16'hFFFF, i == total - 1);
         end
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 7) == 0) read_list($urandom_range(0, 255));
            else read_list($urandom_range(0, total - 1));
         end
         if ($urandom_range(0, 5) == 0) begin
            write_register(CSR_COUNT, $urandom_range(0, 15));
            read_list($urandom_range(0, total - 1));
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_defaults();
      test_wrap_extremes();
      test_zero_period();
      test_count_limits();
      test_equal_distances();
      test_large_set();
      test_random();
      wait_idle();
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 8);
         repeat (stall) begin
            rsp_ch.ready = 1'b0;
            @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_lists.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            want = expected_lists.pop_front();
            if (rsp_ch.data.rank !== want.rank) begin
               $error("rank: expected %0d, actual %0d", want.rank, rsp_ch.data.rank);
               error_count++;
            end
            if (rsp_ch.data.neighbour_index !== want.neighbour_index) begin
               $error("neighbour_index: expected %0d, actual %0d", want.neighbour_index,
                  rsp_ch.data.neighbour_index);
               error_count++;
            end
            if (rsp_ch.data.distance !== want.distance) begin
               $error("distance: expected %0d, actual %0d", want.distance,
                  rsp_ch.data.distance);
               error_count++;
            end
            if (rsp_ch.data.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_ch.data.found);
               error_count++;
            end
            if (rsp_ch.data.last_of_list !== want.last_of_list) begin
               $error("last_of_list: expected %0d, actual %0d", want.last_of_list,
                  rsp_ch.data.last_of_list);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/knnl_pkg.sv
sv/knnl_req_if.sv
sv/knnl_rsp_if.sv
sv/knnl_csr_if.sv
sv/k_nearest_neighbour_lists.sv
bench/testbench.sv
